### rtl/pes_pkg.sv
// ----------------------------------------------------------------------------
// pes_pkg
// Shared codes, defaults and controller/datapath interface types of the
// polygon edge segmenter.
// ----------------------------------------------------------------------------
package pes_pkg;

    localparam int unsigned DEF_SEGMENT_LIMIT = 2048;

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_OFFSET = 2'd1;
    localparam logic [1:0] CMD_VERTEX = 2'd2;
    localparam logic [1:0] CMD_END    = 2'd3;

    localparam logic [2:0] KIND_SEGMENT = 3'd0;
    localparam logic [2:0] KIND_CHANGE  = 3'd1;
    localparam logic [2:0] KIND_HEADER  = 3'd2;
    localparam logic [2:0] KIND_CLOSE   = 3'd3;
    localparam logic [2:0] KIND_WARNING = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;

    localparam logic [1:0] ERR_OUTSIDE     = 2'd0;
    localparam logic [1:0] ERR_NO_STYLE    = 2'd1;
    localparam logic [1:0] ERR_ZERO_CHANGE = 2'd2;
    localparam logic [1:0] ERR_FEW_POINTS  = 2'd3;

    localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_item;
        logic       rel_delta;
        logic       abs_delta;
        logic       edge_begin;
        logic       n_step;
        logic       div_start;
        logic       emit_seg;
        logic       emit_chg;
        logic       emit_hdr;
        logic       emit_close;
        logic       emit_warn;
        logic       emit_err;
        logic [1:0] err_code;
        logic       last;
    } pes_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] command;
        logic       halted;
        logic       start_bad;
        logic       no_style;
        logic       zero_edge;
        logic       change;
        logic       few_points;
        logic       n_more;
        logic       n_last;
        logic       div_done;
        logic       out_free;
    } pes_sts_t;

endpackage

### rtl/pes_divider.sv
// ----------------------------------------------------------------------------
// pes_divider
// Two-lane restoring divider: signed deltas divided by a small positive
// segment count, truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pes_divider #(
    parameter int NW = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [17:0]   num_x,
    input  logic signed [17:0]   num_y,
    input  logic [NW-1:0]        den,
    output logic                 busy,
    output logic signed [17:0]   quo_x,
    output logic signed [17:0]   quo_y
);

    localparam int MW = 18;
    localparam int CW = $clog2(MW + 1);

    logic [CW-1:0] cnt_reg;
    logic [MW-1:0] qx_reg, qy_reg;
    logic [NW:0]   rx_reg, ry_reg;
    logic [NW-1:0] den_reg;
    logic          negx_reg, negy_reg;

    logic [NW:0]   tx, ty;
    logic [NW:0]   rx_next, ry_next;
    logic          bx, by;

    always_comb
    begin
        tx = {rx_reg[NW-1:0], qx_reg[MW-1]};
        ty = {ry_reg[NW-1:0], qy_reg[MW-1]};
        bx = (tx >= {1'b0, den_reg});
        by = (ty >= {1'b0, den_reg});
        rx_next = bx ? (tx - {1'b0, den_reg}) : tx;
        ry_next = by ? (ty - {1'b0, den_reg}) : ty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(MW);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qx_reg   <= num_x[17] ? MW'(-num_x) : MW'(num_x);
            qy_reg   <= num_y[17] ? MW'(-num_y) : MW'(num_y);
            negx_reg <= num_x[17];
            negy_reg <= num_y[17];
            rx_reg   <= '0;
            ry_reg   <= '0;
            den_reg  <= den;
        end
        else if (cnt_reg != '0)
        begin
            qx_reg <= {qx_reg[MW-2:0], bx};
            qy_reg <= {qy_reg[MW-2:0], by};
            rx_reg <= rx_next;
            ry_reg <= ry_next;
        end
    end

    assign busy  = (cnt_reg != '0);
    assign quo_x = negx_reg ? -$signed(qx_reg) : $signed(qx_reg);
    assign quo_y = negy_reg ? -$signed(qy_reg) : $signed(qy_reg);

endmodule

### rtl/pes_datapath.sv
// ----------------------------------------------------------------------------
// pes_datapath
// Item registers, polygon state, edge split arithmetic, map registers and
// the result register of the polygon edge segmenter.
// ----------------------------------------------------------------------------
module pes_datapath #(
    parameter int SEGMENT_LIMIT = pes_pkg::DEF_SEGMENT_LIMIT,
    parameter int NW            = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pes_pkg::pes_cmd_t    cmd,
    output pes_pkg::pes_sts_t    sts,
    input  logic [1:0]           command,
    input  logic signed [16:0]   coord_x,
    input  logic signed [16:0]   coord_y,
    input  logic                 style_present,
    input  logic [7:0]           style,
    input  logic [7:0]           default_edge_style,
    input  logic [9:0]           group_number,
    input  logic                 decor,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic [2:0]           kind,
    output logic signed [16:0]   x_value,
    output logic signed [16:0]   y_value,
    output logic [15:0]          point_index,
    output logic [7:0]           edge_style,
    output logic [19:0]          edge_offset,
    output logic [19:0]          change_offset,
    output logic [15:0]          change_count,
    output logic [1:0]           error_code,
    output logic [9:0]           group_out,
    output logic                 decor_out,
    output logic                 last
);

    localparam logic [17:0] LIMIT_V = 18'(SEGMENT_LIMIT);

    // Accepted item.
    logic [1:0]         cmd_reg;
    logic signed [16:0] cx_reg, cy_reg;
    logic               sp_reg;
    logic [7:0]         st_reg, des_reg;
    logic [9:0]         grp_reg;
    logic               dec_reg;

    // Configuration and polygon state.
    logic [15:0]        map_w_reg, map_h_reg;
    logic signed [17:0] cur_x_reg, cur_y_reg;
    logic [15:0]        points_reg;
    logic [7:0]         active_reg;
    logic [19:0]        segcnt_reg, cwc_reg, pcs_reg;
    logic               halted_reg;

    // Edge in progress.
    logic signed [17:0] dx_reg, dy_reg;
    logic [17:0]        rem_reg;
    logic [NW-1:0]      n_reg;

    logic               rsp_valid_reg;

    logic signed [18:0] diff_x, diff_y;
    logic signed [17:0] sat_x, sat_y;
    logic [17:0]        abs_x, abs_y, m_val;
    logic [19:0]        words;
    logic [15:0]        words_sat;
    logic signed [17:0] quo_x, quo_y;
    logic               div_busy;
    logic               emit_any, out_free;

    logic [2:0]         kind_next;
    logic [16:0]        x_next, y_next;
    logic [15:0]        pidx_next, ccnt_next;
    logic [7:0]         est_next;
    logic [19:0]        eoff_next, coff_next;
    logic [1:0]         err_next;
    logic [9:0]         grp_next;
    logic               dec_next;

    pes_divider #(
        .NW(NW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num_x (dx_reg),
        .num_y (dy_reg),
        .den   (n_reg),
        .busy  (div_busy),
        .quo_x (quo_x),
        .quo_y (quo_y)
    );

    always_comb
    begin
        diff_x = {{2{cx_reg[16]}}, cx_reg} - {cur_x_reg[17], cur_x_reg};
        diff_y = {{2{cy_reg[16]}}, cy_reg} - {cur_y_reg[17], cur_y_reg};
        if (diff_x > 19'sd65535)
            sat_x = 18'sd65535;
        else if (diff_x < -19'sd65535)
            sat_x = -18'sd65535;
        else
            sat_x = diff_x[17:0];
        if (diff_y > 19'sd65535)
            sat_y = 18'sd65535;
        else if (diff_y < -19'sd65535)
            sat_y = -18'sd65535;
        else
            sat_y = diff_y[17:0];
        abs_x = dx_reg[17] ? 18'(-dx_reg) : 18'(dx_reg);
        abs_y = dy_reg[17] ? 18'(-dy_reg) : 18'(dy_reg);
        m_val = (abs_x > abs_y) ? abs_x : abs_y;
        words = cwc_reg - pcs_reg;
        words_sat = (words[19:16] != 4'd0) ? 16'hFFFF : words[15:0];
    end

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign emit_any = cmd.emit_seg | cmd.emit_chg | cmd.emit_hdr | cmd.emit_close
                    | cmd.emit_warn | cmd.emit_err;

    always_comb
    begin
        sts.command    = cmd_reg;
        sts.halted     = halted_reg;
        sts.start_bad  = cx_reg[16] || cy_reg[16] || (cx_reg[15:0] >= map_w_reg)
                         || (cy_reg[15:0] >= map_h_reg);
        sts.no_style   = !sp_reg;
        sts.zero_edge  = (dx_reg == '0) && (dy_reg == '0);
        sts.change     = sp_reg && (st_reg != active_reg);
        sts.few_points = (points_reg < 16'd3);
        sts.n_more     = (rem_reg >= LIMIT_V);
        sts.n_last     = (n_reg == NW'(1));
        sts.div_done   = !div_busy;
        sts.out_free   = out_free;
    end

    // Result fields; the two offsets are always filled, everything else without meaning for the kind stays zero.
    always_comb
    begin
        kind_next = pes_pkg::KIND_SEGMENT;
        x_next    = '0;
        y_next    = '0;
        pidx_next = '0;
        est_next  = '0;
        eoff_next = segcnt_reg;
        coff_next = pcs_reg;
        ccnt_next = '0;
        err_next  = '0;
        grp_next  = '0;
        dec_next  = 1'b0;
        if (cmd.emit_seg)
        begin
            x_next = quo_x[16:0];
            y_next = quo_y[16:0];
        end
        if (cmd.emit_chg)
        begin
            kind_next = pes_pkg::KIND_CHANGE;
            pidx_next = points_reg;
            est_next  = st_reg;
        end
        if (cmd.emit_hdr)
        begin
            kind_next = pes_pkg::KIND_HEADER;
            x_next    = cx_reg;
            y_next    = cy_reg;
            est_next  = st_reg;
            coff_next = cwc_reg;
            grp_next  = grp_reg;
            dec_next  = dec_reg;
        end
        if (cmd.emit_close)
        begin
            kind_next = pes_pkg::KIND_CLOSE;
            pidx_next = points_reg;
            ccnt_next = words_sat;
        end
        if (cmd.emit_warn)
        begin
            kind_next = pes_pkg::KIND_WARNING;
        end
        if (cmd.emit_err)
        begin
            kind_next = pes_pkg::KIND_ERROR;
            err_next  = cmd.err_code;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            cmd_reg <= command;
            cx_reg  <= coord_x;
            cy_reg  <= coord_y;
            sp_reg  <= style_present;
            st_reg  <= style;
            des_reg <= default_edge_style;
            grp_reg <= group_number;
            dec_reg <= decor;
        end
        if (cmd.rel_delta)
        begin
            dx_reg <= {cx_reg[16], cx_reg};
            dy_reg <= {cy_reg[16], cy_reg};
        end
        if (cmd.abs_delta)
        begin
            dx_reg <= sat_x;
            dy_reg <= sat_y;
        end
        if (cmd.edge_begin)
        begin
            rem_reg <= m_val - 18'd1;
            n_reg   <= NW'(1);
        end
        if (cmd.n_step)
        begin
            rem_reg <= rem_reg - LIMIT_V;
            n_reg   <= n_reg + NW'(1);
        end
        if (cmd.emit_seg)
        begin
            dx_reg <= dx_reg - quo_x;
            dy_reg <= dy_reg - quo_y;
            n_reg  <= n_reg - NW'(1);
        end
        if (emit_any)
        begin
            kind          <= kind_next;
            x_value       <= x_next;
            y_value       <= y_next;
            point_index   <= pidx_next;
            edge_style    <= est_next;
            edge_offset   <= eoff_next;
            change_offset <= coff_next;
            change_count  <= ccnt_next;
            error_code    <= err_next;
            group_out     <= grp_next;
            decor_out     <= dec_next;
            last          <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_w_reg     <= 16'hFFFF;
            map_h_reg     <= 16'hFFFF;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            points_reg    <= '0;
            active_reg    <= '0;
            segcnt_reg    <= '0;
            cwc_reg       <= '0;
            pcs_reg       <= '0;
            halted_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == pes_pkg::REG_MAP_WIDTH))
                map_w_reg <= cfg_data;
            if (cfg_we && (cfg_index == pes_pkg::REG_MAP_HEIGHT))
                map_h_reg <= cfg_data;
            if (cmd.emit_err)
                halted_reg <= 1'b1;
            if (cmd.emit_hdr)
            begin
                points_reg <= '0;
                cur_x_reg  <= {cx_reg[16], cx_reg};
                cur_y_reg  <= {cy_reg[16], cy_reg};
                pcs_reg    <= cwc_reg;
                active_reg <= des_reg;
            end
            if (cmd.emit_chg)
            begin
                cwc_reg    <= cwc_reg + 20'd2;
                active_reg <= st_reg;
            end
            if (cmd.emit_close)
                cwc_reg <= cwc_reg + 20'd1;
            if (cmd.edge_begin)
            begin
                cur_x_reg <= cur_x_reg + dx_reg;
                cur_y_reg <= cur_y_reg + dy_reg;
            end
            if (cmd.emit_seg)
            begin
                segcnt_reg <= segcnt_reg + 20'd1;
                if (points_reg != 16'hFFFF)
                    points_reg <= points_reg + 16'd1;
            end
            if (emit_any)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    // A result is only written into a free output register.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit_any |-> out_free)
        else $error("result written over a pending result");

    // Halt is sticky until reset.
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt cleared without reset");

    // The divider never starts with a zero segment count or while running.
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (n_reg != '0) && !div_busy)
        else $error("divider started with bad count or while busy");

    // A segment is only written from a settled quotient.
    a_seg_settled: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_seg |-> !div_busy)
        else $error("segment taken while divider busy");

endmodule

### rtl/pes_ctrl.sv
// ----------------------------------------------------------------------------
// pes_ctrl
// Sequencer of the polygon edge segmenter: decodes each request and steps
// the datapath through checks, segment count, divisions and result writes.
// ----------------------------------------------------------------------------
module pes_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  pes_pkg::pes_sts_t    sts,
    output pes_pkg::pes_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_EDGE    = 4'd2;
    localparam logic [3:0] S_CHG     = 4'd3;
    localparam logic [3:0] S_BEGIN   = 4'd4;
    localparam logic [3:0] S_NCNT    = 4'd5;
    localparam logic [3:0] S_DIVGO   = 4'd6;
    localparam logic [3:0] S_DIVWAIT = 4'd7;
    localparam logic [3:0] S_SEG     = 4'd8;
    localparam logic [3:0] S_WARN    = 4'd9;
    localparam logic [3:0] S_ERR     = 4'd10;
    localparam logic [3:0] S_HDR     = 4'd11;
    localparam logic [3:0] S_CLOSE   = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [1:0] err_reg, err_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        err_next   = err_reg;
        req_stall  = (state_reg != S_IDLE);
        cmd.err_code = err_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (!sts.halted)
                        state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.command)
                    pes_pkg::CMD_START:
                    begin
                        if (sts.start_bad)
                        begin
                            err_next   = pes_pkg::ERR_OUTSIDE;
                            state_next = S_ERR;
                        end
                        else if (sts.no_style)
                        begin
                            err_next   = pes_pkg::ERR_NO_STYLE;
                            state_next = S_ERR;
                        end
                        else
                            state_next = S_HDR;
                    end
                    pes_pkg::CMD_OFFSET:
                    begin
                        cmd.rel_delta = 1'b1;
                        state_next    = S_EDGE;
                    end
                    pes_pkg::CMD_VERTEX:
                    begin
                        cmd.abs_delta = 1'b1;
                        state_next    = S_EDGE;
                    end
                    pes_pkg::CMD_END:
                    begin
                        if (sts.few_points)
                        begin
                            err_next   = pes_pkg::ERR_FEW_POINTS;
                            state_next = S_ERR;
                        end
                        else
                            state_next = S_CLOSE;
                    end
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_EDGE:
            begin
                if (sts.zero_edge)
                    state_next = S_WARN;
                else if (sts.change)
                    state_next = S_CHG;
                else
                    state_next = S_BEGIN;
            end
            S_CHG:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_chg = 1'b1;
                    state_next   = S_BEGIN;
                end
            end
            S_BEGIN:
            begin
                cmd.edge_begin = 1'b1;
                state_next     = S_NCNT;
            end
            S_NCNT:
            begin
                if (sts.n_more)
                    cmd.n_step = 1'b1;
                else
                    state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVWAIT;
            end
            S_DIVWAIT:
            begin
                if (sts.div_done)
                    state_next = S_SEG;
            end
            S_SEG:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_seg = 1'b1;
                    cmd.last     = sts.n_last;
                    state_next   = sts.n_last ? S_IDLE : S_DIVGO;
                end
            end
            S_WARN:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_warn = 1'b1;
                    cmd.last      = !sts.change;
                    if (sts.change)
                    begin
                        err_next   = pes_pkg::ERR_ZERO_CHANGE;
                        state_next = S_ERR;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_err = 1'b1;
                    cmd.last     = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_HDR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_hdr = 1'b1;
                    cmd.last     = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_CLOSE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_close = 1'b1;
                    cmd.last       = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            err_reg   <= pes_pkg::ERR_OUTSIDE;
        end
        else
        begin
            state_reg <= state_next;
            err_reg   <= err_next;
        end
    end

endmodule

### rtl/polygon_edge_segmenter_core.sv
// ----------------------------------------------------------------------------
// polygon_edge_segmenter_core
// Polygon record stream to edge segments, style change, header and close
// records, with map bounds checks and a sticky halt on error.
// ----------------------------------------------------------------------------
// Usage: a request (start, offset, vertex or end) is taken when req_valid is
// high and req_stall is low. Each request yields one to 33 results on the
// rsp channel; the final one of a request carries last. A result is taken
// when rsp_valid is high and rsp_stall is low. Map width and height are
// written on the cfg channel, which is always ready, while the block is idle.
// Sequence: a header, close or error request is decoded and then writes its
// single result. A zero-length edge writes a warning, followed by an error
// when it comes with a style change. Any other edge runs through set-up (with
// a style change record where the style changes), the segment count search,
// and one division per segment in the bit-serial divider, which forms both
// deltas of a segment in 18 steps; an edge has up to 32 segments. One request
// is in work at a time; the next is taken as soon as the last result of the
// previous one sits in the output register, even if it is not yet taken.
// A stalled receiver holds the result register and the sequencer waits.
// Reset clears the polygon state, the halt flag and the output valid flag, and
// sets both map registers to 65535. After an error every request is taken
// and dropped without results until the next reset.
// ----------------------------------------------------------------------------
module polygon_edge_segmenter_core #(
    parameter int SEGMENT_LIMIT = pes_pkg::DEF_SEGMENT_LIMIT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // Request channel.
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic [1:0]           command,
    input  logic signed [16:0]   coord_x,
    input  logic signed [16:0]   coord_y,
    input  logic                 style_present,
    input  logic [7:0]           style,
    input  logic [7:0]           default_edge_style,
    input  logic [9:0]           group_number,
    input  logic                 decor,
    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    // Result channel.
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic [2:0]           kind,
    output logic signed [16:0]   x_value,
    output logic signed [16:0]   y_value,
    output logic [15:0]          point_index,
    output logic [7:0]           edge_style,
    output logic [19:0]          edge_offset,
    output logic [19:0]          change_offset,
    output logic [15:0]          change_count,
    output logic [1:0]           error_code,
    output logic [9:0]           group_out,
    output logic                 decor_out,
    output logic                 last
);

    // Largest segment count of one edge, and the width that holds it.
    localparam int NMAX = 65535 / SEGMENT_LIMIT + 1;
    localparam int NW   = $clog2(NMAX + 1);

    pes_pkg::pes_cmd_t cmd;
    pes_pkg::pes_sts_t sts;

    // Registers are plain flops, so writes are never held off.
    assign cfg_ready = 1'b1;

    pes_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    pes_datapath #(
        .SEGMENT_LIMIT (SEGMENT_LIMIT),
        .NW            (NW)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .command            (command),
        .coord_x            (coord_x),
        .coord_y            (coord_y),
        .style_present      (style_present),
        .style              (style),
        .default_edge_style (default_edge_style),
        .group_number       (group_number),
        .decor              (decor),
        .cfg_we             (cfg_valid && cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .rsp_valid          (rsp_valid),
        .rsp_stall          (rsp_stall),
        .kind               (kind),
        .x_value            (x_value),
        .y_value            (y_value),
        .point_index        (point_index),
        .edge_style         (edge_style),
        .edge_offset        (edge_offset),
        .change_offset      (change_offset),
        .change_count       (change_count),
        .error_code         (error_code),
        .group_out          (group_out),
        .decor_out          (decor_out),
        .last               (last)
    );

endmodule
